// File: hw/rtl/page_bucket_block_allocator_defines.svh
// Assertion macros for the page bucket block allocator.
// Needs i_clk and i_rst_n in the scope of each use.
`ifndef PAGE_BUCKET_BLOCK_ALLOCATOR_DEFINES_SVH
`define PAGE_BUCKET_BLOCK_ALLOCATOR_DEFINES_SVH

`define PBBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define PBBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/pbba_pkg.sv
// Shared constants, control/status types and helper functions of the allocator.
// No dependencies.
package pbba_pkg;

    localparam int PAGE_COUNT_DEF = 16;
    localparam int ADDR_W         = 48;
    localparam int SIZE_W         = 20;
    localparam int SLOT_BITS      = 8;
    localparam int BLK_W          = 9;
    localparam int CNT_W          = 9;
    localparam int BKT_NUM        = 9;
    localparam int BKT_W          = 4;
    localparam int SUM_W          = 10;

    localparam logic [BLK_W-1:0]  BLK_NIL   = 9'd256;
    localparam logic [3:0]        ORD_MIN   = 4'd4;
    localparam logic [3:0]        ORD_MAX   = 4'd12;
    localparam logic [3:0]        ORD_LARGE = 4'd15;
    localparam logic [SIZE_W-1:0] PG_BYTES  = 20'd4096;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef enum logic [16:0] {
        OP_IDLE     = 17'b00000000000000001,
        OP_DECODE   = 17'b00000000000000010,
        OP_FR_CHECK = 17'b00000000000000100,
        OP_FR_LARGE = 17'b00000000000001000,
        OP_FR_SMALL = 17'b00000000000010000,
        OP_FR_BKT   = 17'b00000000000100000,
        OP_FR_WALK  = 17'b00000000001000000,
        OP_FR_PUSH  = 17'b00000000010000000,
        OP_LG_SCAN  = 17'b00000000100000000,
        OP_LG_TAKE  = 17'b00000001000000000,
        OP_LG_FIN   = 17'b00000010000000000,
        OP_SM_WALK  = 17'b00000100000000000,
        OP_SM_NEW   = 17'b00001000000000000,
        OP_SM_CARVE = 17'b00010000000000000,
        OP_SM_POP   = 17'b00100000000000000,
        OP_SM_RD    = 17'b01000000000000000,
        OP_DONE     = 17'b10000000000000000
    } t_op;

    typedef struct packed {
        t_op     op;
        logic    load_out;
        t_status code;
    } t_ctl;

    typedef struct packed {
        logic cmd_free;
        logic size_zero;
        logic size_large;
        logic foreign;
        logic pg_free;
        logic ord_large;
        logic ord_bad;
        logic full;
        logic lg_more;
        logic fr_last;
        logic bkt_hit;
        logic walk_go;
        logic walk_hit;
        logic scan_hit;
        logic scan_end;
        logic take_last;
        logic sw_go;
        logic sw_has;
        logic head_nil;
        logic carve_last;
        logic pop_nil;
    } t_sts;

    function automatic logic [3:0] size_order(input logic [SIZE_W-1:0] size);
        logic [11:0] s;
        logic [3:0]  o;
        s = 12'(size - 20'd1);
        o = 4'd0;
        for (int k = 0; k < 12; k++) begin
            if (s[k]) begin
                o = 4'(k + 1);
            end
        end
        return (o < ORD_MIN) ? ORD_MIN : o;
    endfunction

    function automatic logic [BLK_W-1:0] blk_count(input logic [3:0] ord);
        logic [12:0] full_cnt;
        full_cnt = 13'd4096 >> ord;
        return full_cnt[BLK_W-1:0];
    endfunction

endpackage

// File: hw/rtl/pbba_datapath.sv
// Allocator datapath: page tables, bucket links, block link memory, work registers.
// Depends on pbba_pkg; driven by pbba_ctrl through t_ctl, reports t_sts.
module pbba_datapath #(
    parameter int P_COUNT = pbba_pkg::PAGE_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pbba_pkg::t_ctl                  i_ctl,
    output pbba_pkg::t_sts                  o_sts,
    input  logic                            i_in_xfer,
    input  logic                            i_in_cmd,
    input  logic [pbba_pkg::SIZE_W-1:0]     i_in_size,
    input  logic [pbba_pkg::ADDR_W-1:0]     i_in_addr,
    input  logic                            i_base_we,
    input  logic [pbba_pkg::ADDR_W-1:0]     i_base_wdata,
    output logic [pbba_pkg::ADDR_W-1:0]     o_page_base,
    output logic [pbba_pkg::ADDR_W-1:0]     o_res_addr,
    output pbba_pkg::t_status               o_res_status
);

    localparam int IW = $clog2(P_COUNT);
    localparam int PW = $clog2(P_COUNT + 1);
    localparam int AW = IW + pbba_pkg::SLOT_BITS;
    localparam int MEM_DEPTH = P_COUNT * (2 ** pbba_pkg::SLOT_BITS);
    localparam logic [PW-1:0] PG_NIL = PW'(P_COUNT);
    localparam int BW = pbba_pkg::BLK_W;
    localparam int CW = pbba_pkg::CNT_W;
    localparam int XW = pbba_pkg::ADDR_W;

    logic [XW-1:0]  r_page_base;
    logic           r_is_free  [P_COUNT];
    logic [3:0]     r_order    [P_COUNT];
    logic [BW-1:0]  r_fb       [P_COUNT];
    logic [PW-1:0]  r_next     [P_COUNT];
    logic [PW-1:0]  r_prev     [P_COUNT];
    logic [PW-1:0]  r_bkt_next [P_COUNT];
    logic [BW-1:0]  r_blk_head [P_COUNT];
    logic [PW-1:0]  r_bkt_head [pbba_pkg::BKT_NUM];
    logic [PW-1:0]  r_head;

    logic [BW-1:0]  r_blk_mem [MEM_DEPTH];
    logic [BW-1:0]  r_rdata;

    logic                        r_cmd;
    logic [pbba_pkg::SIZE_W-1:0] r_size;
    logic [XW-1:0]               r_addr;
    logic [XW-1:0]               r_diff;
    logic                        r_below;
    logic [3:0]                  r_ord;
    logic [CW-1:0]               r_need;
    logic [PW-1:0]               r_p;
    logic [PW-1:0]               r_c;
    logic [CW-1:0]               r_cnt;
    logic [CW-1:0]               r_run;
    logic [CW-1:0]               r_n;
    logic [pbba_pkg::SLOT_BITS-1:0] r_idx;
    logic [XW-1:0]               r_res;
    logic [XW-1:0]               r_out_addr;
    pbba_pkg::t_status           r_out_status;

    logic [IW-1:0]  fp, pi, ci, qi, hi, uk, pk;
    logic [3:0]     pg_ord, so_ord;
    logic [pbba_pkg::BKT_W-1:0] bkt, so_bkt;
    logic [BW-1:0]  blocks, maxb_pg;
    logic [pbba_pkg::SUM_W-1:0] q;
    logic           p_valid, c_valid, q_valid, head_valid;
    logic           scan_fr;
    logic [CW-1:0]  run_n;
    logic [PW-1:0]  start_n;
    logic [pbba_pkg::SLOT_BITS-1:0] fidx;
    logic [11:0]    blk_off;
    logic [XW-1:0]  page_off;
    logic [XW-1:0]  pg_only;
    logic           u_en, k_en;
    logic [PW-1:0]  u_nx, u_pv;
    logic           mem_we;
    logic [AW-1:0]  mem_wa, mem_ra;
    logic [BW-1:0]  mem_wd;
    logic [CW-1:0]  cnt_inc;
    logic [20:0]    need_sum;

    always_comb begin
        fp       = r_diff[12 +: IW];
        pi       = r_p[IW-1:0];
        ci       = r_c[IW-1:0];
        hi       = r_head[IW-1:0];
        q        = pbba_pkg::SUM_W'(r_p) + pbba_pkg::SUM_W'(r_cnt);
        qi       = q[IW-1:0];
        p_valid  = r_p < PG_NIL;
        c_valid  = r_c < PG_NIL;
        q_valid  = q < pbba_pkg::SUM_W'(P_COUNT);
        head_valid = r_head < PG_NIL;
        pg_ord   = r_order[fp];
        so_ord   = pbba_pkg::size_order(r_size);
        so_bkt   = so_ord - pbba_pkg::ORD_MIN;
        bkt      = r_ord - pbba_pkg::ORD_MIN;
        blocks   = pbba_pkg::blk_count(r_ord);
        maxb_pg  = pbba_pkg::blk_count(pg_ord);
        scan_fr  = r_is_free[r_cnt[IW-1:0]];
        run_n    = scan_fr ? CW'(r_run + 1'b1) : '0;
        start_n  = (scan_fr && (r_run == '0)) ? PW'(r_cnt) : r_p;
        fidx     = pbba_pkg::SLOT_BITS'(r_diff[11:0] >> r_ord);
        blk_off  = 12'({4'd0, r_idx} << r_ord);
        pg_only  = XW'(pi) << 12;
        page_off = pg_only | XW'(blk_off);
        cnt_inc  = CW'(r_cnt + 1'b1);
        need_sum = 21'(r_size) + 21'd4095;
    end

    always_comb begin
        o_sts.cmd_free   = r_cmd;
        o_sts.size_zero  = (r_size == '0);
        o_sts.size_large = (r_size > pbba_pkg::PG_BYTES);
        o_sts.foreign    = r_below || (r_diff[XW-1:12] >= (XW-12)'(P_COUNT));
        o_sts.pg_free    = r_is_free[fp];
        o_sts.ord_large  = (pg_ord == pbba_pkg::ORD_LARGE);
        o_sts.ord_bad    = (pg_ord < pbba_pkg::ORD_MIN) || (pg_ord > pbba_pkg::ORD_MAX);
        o_sts.full       = (r_fb[fp] >= maxb_pg);
        o_sts.lg_more    = (r_cnt < r_n) && q_valid;
        o_sts.fr_last    = (BW'(r_fb[pi] + 1'b1) == blocks);
        o_sts.bkt_hit    = (r_bkt_head[bkt] == r_p);
        o_sts.walk_go    = c_valid && (r_cnt < CW'(P_COUNT));
        o_sts.walk_hit   = (r_bkt_next[ci] == r_p);
        o_sts.scan_hit   = (run_n == r_need);
        o_sts.scan_end   = (r_cnt == CW'(P_COUNT - 1));
        o_sts.take_last  = (cnt_inc == r_need);
        o_sts.sw_go      = p_valid && (r_fb[pi] == '0) && (r_cnt < CW'(P_COUNT));
        o_sts.sw_has     = p_valid && (r_fb[pi] != '0);
        o_sts.head_nil   = !head_valid;
        o_sts.carve_last = (cnt_inc == blocks);
        o_sts.pop_nil    = r_blk_head[pi][BW-1];
    end

    always_comb begin
        u_en = 1'b0;
        uk   = qi;
        k_en = 1'b0;
        pk   = pi;
        case (i_ctl.op)
            pbba_pkg::OP_LG_TAKE: begin
                u_en = 1'b1;
                uk   = qi;
            end
            pbba_pkg::OP_SM_NEW: begin
                u_en = head_valid;
                uk   = hi;
            end
            pbba_pkg::OP_FR_LARGE: begin
                k_en = o_sts.lg_more && !r_is_free[qi];
                pk   = qi;
            end
            pbba_pkg::OP_FR_PUSH: begin
                k_en = 1'b1;
                pk   = pi;
            end
            default: begin
                u_en = 1'b0;
            end
        endcase
        u_nx = r_next[uk];
        u_pv = r_prev[uk];
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = {pi, fidx};
        mem_wd = r_blk_head[pi];
        case (i_ctl.op)
            pbba_pkg::OP_FR_SMALL: begin
                mem_we = 1'b1;
            end
            pbba_pkg::OP_SM_CARVE: begin
                mem_we = 1'b1;
                mem_wa = {pi, r_cnt[pbba_pkg::SLOT_BITS-1:0]};
                mem_wd = o_sts.carve_last ? pbba_pkg::BLK_NIL : cnt_inc;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
        mem_ra = {pi, r_blk_head[pi][pbba_pkg::SLOT_BITS-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_blk_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_blk_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_base <= '0;
            r_head      <= PW'(P_COUNT - 1);
            for (int i = 0; i < P_COUNT; i++) begin
                r_is_free[i]  <= 1'b1;
                r_order[i]    <= '0;
                r_fb[i]       <= '0;
                r_next[i]     <= (i == 0) ? PG_NIL : PW'(i - 1);
                r_prev[i]     <= (i + 1 < P_COUNT) ? PW'(i + 1) : PG_NIL;
                r_bkt_next[i] <= PG_NIL;
                r_blk_head[i] <= pbba_pkg::BLK_NIL;
            end
            for (int b = 0; b < pbba_pkg::BKT_NUM; b++) begin
                r_bkt_head[b] <= PG_NIL;
            end
        end else begin
            if (i_base_we) begin
                r_page_base <= i_base_wdata;
            end
            if (u_en && r_is_free[uk]) begin
                if (u_pv < PG_NIL) begin
                    r_next[u_pv[IW-1:0]] <= u_nx;
                end else begin
                    r_head <= u_nx;
                end
                if (u_nx < PG_NIL) begin
                    r_prev[u_nx[IW-1:0]] <= u_pv;
                end
                r_next[uk]    <= PG_NIL;
                r_prev[uk]    <= PG_NIL;
                r_is_free[uk] <= 1'b0;
            end
            if (k_en) begin
                r_is_free[pk]  <= 1'b1;
                r_order[pk]    <= '0;
                r_fb[pk]       <= '0;
                r_blk_head[pk] <= pbba_pkg::BLK_NIL;
                r_next[pk]     <= r_head;
                r_prev[pk]     <= PG_NIL;
                if (head_valid) begin
                    r_prev[hi] <= PW'(pk);
                end
                r_head <= PW'(pk);
            end
            case (i_ctl.op)
                pbba_pkg::OP_IDLE: begin
                    if (i_in_xfer) begin
                        r_cmd  <= i_in_cmd;
                        r_size <= i_in_size;
                        r_addr <= i_in_addr;
                    end
                end
                pbba_pkg::OP_DECODE: begin
                    r_diff  <= r_addr - r_page_base;
                    r_below <= r_addr < r_page_base;
                    r_ord   <= so_ord;
                    r_need  <= CW'(need_sum >> 12);
                    r_cnt   <= '0;
                    r_run   <= '0;
                    r_p     <= o_sts.size_large ? '0 : r_bkt_head[so_bkt];
                end
                pbba_pkg::OP_FR_CHECK: begin
                    r_p   <= PW'(fp);
                    r_ord <= pg_ord;
                    r_n   <= r_fb[fp];
                    r_cnt <= '0;
                end
                pbba_pkg::OP_FR_LARGE: begin
                    if (o_sts.lg_more) begin
                        r_cnt <= cnt_inc;
                    end
                end
                pbba_pkg::OP_FR_SMALL: begin
                    r_blk_head[pi] <= BW'(fidx);
                    r_fb[pi]       <= BW'(r_fb[pi] + 1'b1);
                end
                pbba_pkg::OP_FR_BKT: begin
                    if (o_sts.bkt_hit) begin
                        r_bkt_head[bkt] <= r_bkt_next[pi];
                    end else begin
                        r_c   <= r_bkt_head[bkt];
                        r_cnt <= '0;
                    end
                end
                pbba_pkg::OP_FR_WALK: begin
                    if (o_sts.walk_go) begin
                        if (o_sts.walk_hit) begin
                            r_bkt_next[ci] <= r_bkt_next[pi];
                        end else begin
                            r_c   <= r_bkt_next[ci];
                            r_cnt <= cnt_inc;
                        end
                    end
                end
                pbba_pkg::OP_FR_PUSH: begin
                    r_bkt_next[pi] <= PG_NIL;
                end
                pbba_pkg::OP_LG_SCAN: begin
                    r_p <= start_n;
                    if (o_sts.scan_hit) begin
                        r_cnt <= '0;
                    end else begin
                        r_run <= run_n;
                        r_cnt <= cnt_inc;
                    end
                end
                pbba_pkg::OP_LG_TAKE: begin
                    r_cnt <= cnt_inc;
                end
                pbba_pkg::OP_LG_FIN: begin
                    r_order[pi] <= pbba_pkg::ORD_LARGE;
                    r_fb[pi]    <= r_need;
                    r_res       <= r_page_base + pg_only;
                end
                pbba_pkg::OP_SM_WALK: begin
                    if (o_sts.sw_go) begin
                        r_p   <= r_bkt_next[pi];
                        r_cnt <= cnt_inc;
                    end
                end
                pbba_pkg::OP_SM_NEW: begin
                    if (head_valid) begin
                        r_p             <= r_head;
                        r_order[hi]     <= r_ord;
                        r_bkt_next[hi]  <= r_bkt_head[bkt];
                        r_bkt_head[bkt] <= r_head;
                        r_blk_head[hi]  <= '0;
                        r_fb[hi]        <= blocks;
                        r_cnt           <= '0;
                    end
                end
                pbba_pkg::OP_SM_CARVE: begin
                    r_cnt <= cnt_inc;
                end
                pbba_pkg::OP_SM_POP: begin
                    r_idx <= r_blk_head[pi][pbba_pkg::SLOT_BITS-1:0];
                end
                pbba_pkg::OP_SM_RD: begin
                    r_blk_head[pi] <= r_rdata;
                    r_fb[pi]       <= BW'(r_fb[pi] - 1'b1);
                    r_res          <= r_page_base + page_off;
                end
                pbba_pkg::OP_DONE: begin
                    if (i_ctl.load_out) begin
                        r_out_addr   <= ((i_ctl.code == pbba_pkg::ST_OK) && !r_cmd) ?
                                        r_res : '0;
                        r_out_status <= i_ctl.code;
                    end
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

    assign o_page_base  = r_page_base;
    assign o_res_addr   = r_out_addr;
    assign o_res_status = r_out_status;

endmodule

// File: hw/rtl/pbba_ctrl.sv
// Allocator controller: one-hot sequencer over decode, scans, walks, carve and result.
// Depends on pbba_pkg; reads t_sts from pbba_datapath and drives t_ctl.
module pbba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  pbba_pkg::t_sts i_sts,
    output pbba_pkg::t_ctl o_ctl
);

    pbba_pkg::t_op     r_state, n_state;
    pbba_pkg::t_status r_code, n_code;
    logic              r_out_valid;
    logic              out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = i_rst_n && (r_state == pbba_pkg::OP_IDLE);

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        case (r_state)
            pbba_pkg::OP_IDLE: begin
                if (i_in_valid) begin
                    n_state = pbba_pkg::OP_DECODE;
                end
            end
            pbba_pkg::OP_DECODE: begin
                if (i_sts.cmd_free) begin
                    n_state = pbba_pkg::OP_FR_CHECK;
                end else if (i_sts.size_zero) begin
                    n_state = pbba_pkg::OP_DONE;
                    n_code  = pbba_pkg::ST_INVALID;
                end else if (i_sts.size_large) begin
                    n_state = pbba_pkg::OP_LG_SCAN;
                end else begin
                    n_state = pbba_pkg::OP_SM_WALK;
                end
            end
            pbba_pkg::OP_FR_CHECK: begin
                if (i_sts.foreign || i_sts.pg_free) begin
                    n_state = pbba_pkg::OP_DONE;
                    n_code  = pbba_pkg::ST_INVALID;
                end else if (i_sts.ord_large) begin
                    n_state = pbba_pkg::OP_FR_LARGE;
                end else if (i_sts.ord_bad || i_sts.full) begin
                    n_state = pbba_pkg::OP_DONE;
                    n_code  = pbba_pkg::ST_INVALID;
                end else begin
                    n_state = pbba_pkg::OP_FR_SMALL;
                end
            end
            pbba_pkg::OP_FR_LARGE: begin
                if (!i_sts.lg_more) begin
                    n_state = pbba_pkg::OP_DONE;
                    n_code  = pbba_pkg::ST_OK;
                end
            end
            pbba_pkg::OP_FR_SMALL: begin
                if (i_sts.fr_last) begin
                    n_state = pbba_pkg::OP_FR_BKT;
                end else begin
                    n_state = pbba_pkg::OP_DONE;
                    n_code  = pbba_pkg::ST_OK;
                end
            end
            pbba_pkg::OP_FR_BKT: begin
                n_state = i_sts.bkt_hit ? pbba_pkg::OP_FR_PUSH : pbba_pkg::OP_FR_WALK;
            end
            pbba_pkg::OP_FR_WALK: begin
                if (!i_sts.walk_go || i_sts.walk_hit) begin
                    n_state = pbba_pkg::OP_FR_PUSH;
                end
            end
            pbba_pkg::OP_FR_PUSH: begin
                n_state = pbba_pkg::OP_DONE;
                n_code  = pbba_pkg::ST_OK;
            end
            pbba_pkg::OP_LG_SCAN: begin
                if (i_sts.scan_hit) begin
                    n_state = pbba_pkg::OP_LG_TAKE;
                end else if (i_sts.scan_end) begin
                    n_state = pbba_pkg::OP_DONE;
                    n_code  = pbba_pkg::ST_OOM;
                end
            end
            pbba_pkg::OP_LG_TAKE: begin
                if (i_sts.take_last) begin
                    n_state = pbba_pkg::OP_LG_FIN;
                end
            end
            pbba_pkg::OP_LG_FIN: begin
                n_state = pbba_pkg::OP_DONE;
                n_code  = pbba_pkg::ST_OK;
            end
            pbba_pkg::OP_SM_WALK: begin
                if (!i_sts.sw_go) begin
                    n_state = i_sts.sw_has ? pbba_pkg::OP_SM_POP : pbba_pkg::OP_SM_NEW;
                end
            end
            pbba_pkg::OP_SM_NEW: begin
                if (i_sts.head_nil) begin
                    n_state = pbba_pkg::OP_DONE;
                    n_code  = pbba_pkg::ST_OOM;
                end else begin
                    n_state = pbba_pkg::OP_SM_CARVE;
                end
            end
            pbba_pkg::OP_SM_CARVE: begin
                if (i_sts.carve_last) begin
                    n_state = pbba_pkg::OP_SM_POP;
                end
            end
            pbba_pkg::OP_SM_POP: begin
                if (i_sts.pop_nil) begin
                    n_state = pbba_pkg::OP_DONE;
                    n_code  = pbba_pkg::ST_OOM;
                end else begin
                    n_state = pbba_pkg::OP_SM_RD;
                end
            end
            pbba_pkg::OP_SM_RD: begin
                n_state = pbba_pkg::OP_DONE;
                n_code  = pbba_pkg::ST_OK;
            end
            pbba_pkg::OP_DONE: begin
                if (out_free) begin
                    n_state = pbba_pkg::OP_IDLE;
                end
            end
            default: begin
                n_state = pbba_pkg::OP_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pbba_pkg::OP_IDLE;
            r_code      <= pbba_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
            if ((r_state == pbba_pkg::OP_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_ctl.op       = r_state;
    assign o_ctl.load_out = (r_state == pbba_pkg::OP_DONE) && out_free;
    assign o_ctl.code     = r_code;
    assign o_out_valid    = r_out_valid;

endmodule

// File: hw/rtl/page_bucket_block_allocator.sv
// Top level of the page bucket block allocator: stream ports, register port, assertions.
// Depends on pbba_pkg, pbba_ctrl, pbba_datapath and the allocator defines header.
//
//  channel   | direction | handshake                      | payload
//  s_axis    | in        | i_s_axis_tvalid/o_s_axis_tready| tuser cmd, tdata size+addr
//  m_axis    | out       | o_m_axis_tvalid/i_m_axis_tready| tuser status, tdata address
//  apb       | in        | i_psel/i_penable, o_pready=1   | page_base at byte address 0
//
// One request at a time. A page scan looks for a run of free pages; pages are then taken
// or released one per cycle, and when a new page enters a bucket its blocks (up to 256)
// are carved one per cycle, since the block link memory has a single write port. The
// bucket walks stop after PAGE_COUNT pages each.
// Reset is synchronous; the link memory needs no clearing pass.
// A result waiting in the output register does not block the next request until done.
`include "page_bucket_block_allocator_defines.svh"

module page_bucket_block_allocator #(
    parameter int PAGE_COUNT = pbba_pkg::PAGE_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,   // [19:0] req_size, [67:20] free_addr, rest zero
    input  logic        i_s_axis_tuser,   // [0] cmd
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [47:0] result_addr
    output logic [1:0]  o_m_axis_tuser,   // [1:0] status
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [63:0] i_pwdata,
    output logic [63:0] o_prdata,
    output logic        o_pready
);

    pbba_pkg::t_ctl    ctl;
    pbba_pkg::t_sts    sts;
    pbba_pkg::t_status res_status;
    logic [47:0]       page_base;
    logic              in_xfer;
    logic              reg_sel;
    logic              base_we;

    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign reg_sel  = (i_paddr[3] == 1'b0);
    assign base_we  = i_psel && i_penable && i_pwrite && o_pready && reg_sel;
    assign o_pready = 1'b1;
    assign o_prdata = reg_sel ? {16'd0, page_base} : '0;

    pbba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    pbba_datapath #(
        .P_COUNT (PAGE_COUNT)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .o_sts        (sts),
        .i_in_xfer    (in_xfer),
        .i_in_cmd     (i_s_axis_tuser),
        .i_in_size    (i_s_axis_tdata[19:0]),
        .i_in_addr    (i_s_axis_tdata[67:20]),
        .i_base_we    (base_we),
        .i_base_wdata (i_pwdata[47:0]),
        .o_page_base  (page_base),
        .o_res_addr   (o_m_axis_tdata),
        .o_res_status (res_status)
    );

    assign o_m_axis_tuser = res_status;

    `PBBA_ASSERT_NEXT(a_accept_decodes, in_xfer, ctl.op == pbba_pkg::OP_DECODE, "transfer not decoded")
    `PBBA_ASSERT_NOW(a_no_overwrite, ctl.load_out, !o_m_axis_tvalid || i_m_axis_tready, "result overwritten")
    `PBBA_ASSERT_NOW(a_fail_zero, o_m_axis_tvalid && (o_m_axis_tuser != pbba_pkg::ST_OK), o_m_axis_tdata == 48'd0, "failed result has address")

endmodule

// File: tb/sv/page_bucket_block_allocator_tb.sv
// Self-checking testbench for page_bucket_block_allocator: stream driver and monitor,
// APB writes of page_base, and an in-bench allocator predictor. Depends on pbba_pkg.
module page_bucket_block_allocator_tb;

    localparam int  NPAGE    = 16;
    localparam int  PG_NULL  = NPAGE;
    localparam int  BLK_NULL = 256;
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;
    localparam logic [3:0] REG_PAGE_BASE = 4'd0;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic        cmd;
        logic [19:0] size;
        logic [47:0] addr;
    } t_req;

    typedef struct {
        logic              [47:0] addr;
        pbba_pkg::t_status status;
        logic              cmd;
    } t_outcome;

    logic        i_clk, i_rst_n;
    logic        i_s_axis_tvalid, o_s_axis_tready;
    logic [71:0] i_s_axis_tdata;
    logic        i_s_axis_tuser;
    logic        o_m_axis_tvalid, i_m_axis_tready;
    logic [47:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        i_psel, i_penable, i_pwrite;
    logic [3:0]  i_paddr;
    logic [63:0] i_pwdata;
    logic [63:0] o_prdata;
    logic        o_pready;

    page_bucket_block_allocator dut (.*);

    // predictor state
    logic [47:0] base_q;
    bit          pg_free   [NPAGE];
    int          pg_order  [NPAGE];
    int          pg_nfree  [NPAGE];
    int          fp_next   [NPAGE];
    int          fp_prev   [NPAGE];
    int          fp_head;
    int          bkt_head  [9];
    int          bkt_next  [NPAGE];
    int          blk_head  [NPAGE];
    int          blk_next  [NPAGE*256];

    t_req        pending[$];
    t_outcome    expected[$];
    logic [47:0] live_offs[$];
    int          send_idle, recv_stall;
    int          hold_start, hold_seen, hold_left;
    int          errors, n_alloc_ok, n_free_ok, n_oom, n_invalid;
    longint      cycles;
    t_req        cur;

    function automatic void push_page(int p);
        pg_free[p] = 1; pg_order[p] = 0; pg_nfree[p] = 0; blk_head[p] = BLK_NULL;
        fp_next[p] = fp_head; fp_prev[p] = PG_NULL;
        if (fp_head < NPAGE) fp_prev[fp_head] = p;
        fp_head = p;
    endfunction

    function automatic void unlink_page(int p);
        int nx, pv;
        nx = fp_next[p]; pv = fp_prev[p];
        if (!pg_free[p]) return;
        if (pv < NPAGE) fp_next[pv] = nx; else fp_head = nx;
        if (nx < NPAGE) fp_prev[nx] = pv;
        fp_next[p] = PG_NULL; fp_prev[p] = PG_NULL; pg_free[p] = 0;
    endfunction

    function automatic pbba_pkg::t_status take_run(logic [19:0] size, output logic [47:0] a);
        int need, run, start;
        need = (int'(size) + 4095) >> 12;
        run = 0; start = 0; a = '0;
        for (int i = 0; i < NPAGE; i++) begin
            if (pg_free[i]) begin
                if (run == 0) start = i;
                run++;
            end else begin
                run = 0;
            end
            if (run == need) begin
                for (int k = 0; k < need; k++) unlink_page(start + k);
                pg_order[start] = pbba_pkg::ORD_LARGE;
                pg_nfree[start] = need;
                a = base_q + (48'(start) << 12);
                return pbba_pkg::ST_OK;
            end
        end
        return pbba_pkg::ST_OOM;
    endfunction

    function automatic pbba_pkg::t_status take_block(logic [19:0] size, output logic [47:0] a);
        int o, b, p, steps, nblk, idx;
        o = 0;
        while (o < 20 && (1 << o) < int'(size)) o++;
        if (o < 4) o = 4;
        b = o - 4; p = bkt_head[b]; steps = 0; a = '0;
        while (p < NPAGE && pg_nfree[p] == 0 && steps < NPAGE) begin
            p = bkt_next[p]; steps++;
        end
        if (p >= NPAGE || pg_nfree[p] == 0) begin
            if (fp_head >= NPAGE) return pbba_pkg::ST_OOM;
            p = fp_head;
            unlink_page(p);
            pg_order[p] = o;
            bkt_next[p] = bkt_head[b];
            bkt_head[b] = p;
            nblk = 4096 >> o;
            for (int i = 0; i + 1 < nblk; i++) blk_next[p*256 + i] = i + 1;
            blk_next[p*256 + nblk - 1] = BLK_NULL;
            blk_head[p] = 0;
            pg_nfree[p] = nblk;
        end
        idx = blk_head[p];
        if (idx >= 256) return pbba_pkg::ST_OOM;
        blk_head[p] = blk_next[p*256 + idx];
        pg_nfree[p]--;
        a = base_q + (48'(p) << 12) + (48'(idx) << o);
        return pbba_pkg::ST_OK;
    endfunction

    function automatic pbba_pkg::t_status release_block(logic [47:0] a);
        logic [47:0] diff;
        int p, o, maxb, idx, c, steps, b, n;
        if (a < base_q) return pbba_pkg::ST_INVALID;
        diff = a - base_q;
        if ((diff >> 12) >= NPAGE) return pbba_pkg::ST_INVALID;
        p = int'(diff >> 12);
        if (pg_free[p]) return pbba_pkg::ST_INVALID;
        o = pg_order[p];
        if (o == pbba_pkg::ORD_LARGE) begin
            n = pg_nfree[p];
            for (int i = 0; i < n && p + i < NPAGE; i++)
                if (!pg_free[p+i]) push_page(p + i);
            return pbba_pkg::ST_OK;
        end
        if (o < 4 || o > 12) return pbba_pkg::ST_INVALID;
        maxb = 4096 >> o;
        if (pg_nfree[p] >= maxb) return pbba_pkg::ST_INVALID;
        idx = int'(diff[11:0]) >> o;
        blk_next[p*256 + idx] = blk_head[p];
        blk_head[p] = idx;
        pg_nfree[p]++;
        if (pg_nfree[p] == maxb) begin
            b = o - 4;
            if (bkt_head[b] == p) begin
                bkt_head[b] = bkt_next[p];
            end else begin
                c = bkt_head[b]; steps = 0;
                while (c < NPAGE && steps < NPAGE) begin
                    if (bkt_next[c] == p) begin
                        bkt_next[c] = bkt_next[p];
                        break;
                    end
                    c = bkt_next[c]; steps++;
                end
            end
            bkt_next[p] = PG_NULL;
            push_page(p);
        end
        return pbba_pkg::ST_OK;
    endfunction

    function automatic t_outcome serve_request(t_req r);
        t_outcome e;
        e.addr = '0; e.cmd = r.cmd;
        if (r.cmd == CMD_FREE) e.status = release_block(r.addr);
        else if (r.size == 0) e.status = pbba_pkg::ST_INVALID;
        else if (r.size > 20'd4096) e.status = take_run(r.size, e.addr);
        else e.status = take_block(r.size, e.addr);
        if (e.status != pbba_pkg::ST_OK) e.addr = '0;
        return e;
    endfunction

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycles);
            $display("page_bucket_block_allocator regression: fail");
            $finish;
        end
    end

    // driver: hold each item until its transfer, then predict it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) expected.push_back(serve_request(cur));
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
                    cur = pending.pop_front();
                    i_s_axis_tdata  <= {4'b0, cur.addr, cur.size};
                    i_s_axis_tuser  <= cur.cmd;
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver backpressure
    always @(posedge i_clk) begin
        t_outcome e;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result: addr %h status %0d", $time,
                             o_m_axis_tdata, o_m_axis_tuser);
                end else begin
                    e = expected.pop_front();
                    if (o_m_axis_tdata !== e.addr || o_m_axis_tuser !== e.status) begin
                        errors++;
                        $display("%0t mismatch: expected addr %h status %0d, got addr %h status %0d",
                                 $time, e.addr, e.status, o_m_axis_tdata, o_m_axis_tuser);
                    end
                    if (e.status == pbba_pkg::ST_OK && e.cmd == CMD_ALLOC) begin
                        live_offs.push_back(e.addr - base_q);
                        n_alloc_ok++;
                    end
                    if (e.status == pbba_pkg::ST_OK && e.cmd == CMD_FREE) n_free_ok++;
                    if (e.status == pbba_pkg::ST_OOM) n_oom++;
                    if (e.status == pbba_pkg::ST_INVALID) n_invalid++;
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_m_axis_tready <= 1'b0;
            end else if (hold_start != hold_seen) begin
                hold_seen <= hold_start;
                hold_left <= 600;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    task automatic write_base(logic [47:0] v);
        @(posedge i_clk);
        i_psel <= 1'b1; i_penable <= 1'b0; i_pwrite <= 1'b1;
        i_paddr <= REG_PAGE_BASE; i_pwdata <= {16'b0, v};
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        i_psel <= 1'b0; i_penable <= 1'b0; i_pwrite <= 1'b0;
        base_q = v;
    endtask

    task automatic add_req(logic cmd, logic [19:0] size, logic [47:0] addr);
        t_req r;
        r.cmd = cmd; r.size = size; r.addr = addr;
        pending.push_back(r);
    endtask

    task automatic drain();
        while (pending.size() > 0 || expected.size() > 0 || i_s_axis_tvalid)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    task automatic add_random();
        int k, sel, idx;
        logic [47:0] a;
        sel = $urandom_range(99);
        k = (live_offs.size() > 40) ? 60 : 35;
        if (sel < k) begin
            sel = $urandom_range(99);
            if (sel < 65 && live_offs.size() > 0) begin
                idx = $urandom_range(live_offs.size() - 1);
                a = base_q + live_offs[idx];
                live_offs.delete(idx);
                if ($urandom_range(9) == 0) a = a + 48'($urandom_range(15));
            end else if (sel < 80 && live_offs.size() > 0) begin
                a = base_q + live_offs[$urandom_range(live_offs.size() - 1)]
                    + 48'($urandom_range(1, 3)) * 4096;
            end else if (sel < 92) begin
                a = base_q + 48'($urandom_range(NPAGE*4096 + 8191));
            end else if (sel < 96) begin
                a = base_q - 48'($urandom_range(1, 8192));
            end else begin
                a = rand48();
            end
            add_req(CMD_FREE, 20'($urandom), a);
        end else begin
            sel = $urandom_range(99);
            if (sel < 75)
                add_req(CMD_ALLOC, 20'($urandom_range(1, 1 << $urandom_range(0, 12))), rand48());
            else if (sel < 92)
                add_req(CMD_ALLOC, 20'($urandom_range(4097, 5 * 4096)), rand48());
            else if (sel < 96)
                add_req(CMD_ALLOC, 20'($urandom_range(4097, 20'hFFFFF)), rand48());
            else
                add_req(CMD_ALLOC, 20'd0, rand48());
        end
    endtask

    task automatic run_phase(int idle, int stall, logic [47:0] pbase, bit pressure);
        write_base(pbase);
        send_idle = idle; recv_stall = stall;
        if (pressure) begin
            repeat (40) add_random();
            hold_start++;
        end
        for (int n = pressure ? 40 : 0; n < 326; n++) begin
            while (pending.size() > 4) @(posedge i_clk);
            add_random();
        end
        drain();
    endtask

    initial begin
        i_rst_n = 0; i_s_axis_tvalid = 0; i_s_axis_tdata = '0; i_s_axis_tuser = 0;
        i_m_axis_tready = 0; i_psel = 0; i_penable = 0; i_pwrite = 0;
        i_paddr = '0; i_pwdata = '0;
        errors = 0; n_alloc_ok = 0; n_free_ok = 0; n_oom = 0; n_invalid = 0;
        cycles = 0; hold_start = 0; hold_seen = 0; hold_left = 0;
        send_idle = 0; recv_stall = 0; base_q = '0;
        for (int i = 0; i < NPAGE; i++) begin
            pg_free[i] = 1; pg_order[i] = 0; pg_nfree[i] = 0;
            fp_next[i] = (i == 0) ? PG_NULL : i - 1;
            fp_prev[i] = (i + 1 < NPAGE) ? i + 1 : PG_NULL;
            bkt_next[i] = PG_NULL; blk_head[i] = BLK_NULL;
        end
        fp_head = NPAGE - 1;
        for (int i = 0; i < 9; i++) bkt_head[i] = PG_NULL;
        for (int i = 0; i < NPAGE*256; i++) blk_next[i] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_base(48'h10000);
        add_req(CMD_ALLOC, 20'd0, 48'hFFFF_FFFF_FFFF);
        add_req(CMD_ALLOC, 20'd1, '0);
        add_req(CMD_ALLOC, 20'd16, '0);
        add_req(CMD_ALLOC, 20'd17, '0);
        add_req(CMD_ALLOC, 20'd4096, '0);
        add_req(CMD_ALLOC, 20'd4097, '0);
        add_req(CMD_FREE, 20'hFFFFF, 48'h11000);
        add_req(CMD_FREE, 20'd0, 48'h10000);
        add_req(CMD_FREE, 20'd0, 48'h10000);
        add_req(CMD_FREE, 20'd0, 48'h0FFFF);
        add_req(CMD_FREE, 20'd0, 48'h20000);
        add_req(CMD_FREE, 20'd0, 48'h1F013);
        add_req(CMD_FREE, 20'd0, 48'h1F000);
        add_req(CMD_ALLOC, 20'hFFFFF, '0);
        add_req(CMD_ALLOC, 20'd65536, '0);
        add_req(CMD_FREE, 20'd0, 48'h1E000);
        add_req(CMD_FREE, 20'd0, 48'h1D000);
        add_req(CMD_ALLOC, 20'd65536, '0);
        add_req(CMD_ALLOC, 20'd8, '0);
        add_req(CMD_FREE, 20'd0, 48'h10000);
        add_req(CMD_ALLOC, 20'd2048, '0);
        add_req(CMD_ALLOC, 20'd512, '0);
        add_req(CMD_ALLOC, 20'd128, '0);
        drain();

        run_phase(0, 0, 48'h0, 0);
        run_phase(84, 0, 48'hFFFF_FFFF_F000, 0);
        run_phase(0, 84, {16'($urandom_range(1, 16'hFFFF)), 20'($urandom_range(1, 20'hFFFFF)),
                          12'h0}, 0);
        run_phase(36, 36, 48'h10000, 0);
        run_phase(0, 0, 48'h0, 1);
        repeat (50) @(posedge i_clk);

        $display("covered %0d good allocations, %0d good frees, %0d out of memory, %0d rejected",
                 n_alloc_ok, n_free_ok, n_oom, n_invalid);
        $display("across five page_base settings and mixed stall patterns, %0d mismatches",
                 errors);
        if (errors == 0 && expected.size() == 0) begin
            $display("page_bucket_block_allocator regression: pass");
        end else begin
            $display("page_bucket_block_allocator regression: fail");
        end
        $finish;
    end
endmodule
